FILE: design/stlr_pkg.sv
package stlr_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_REDRAW = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  localparam logic [7:0] CMD_GOTO_X = 8'h80;
  localparam logic [7:0] CMD_GOTO_Y = 8'h40;
  localparam logic [7:0] SPACER     = 8'h00;

  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_COUNT = 51;
  localparam logic [5:0] BLANK_GLYPH = 6'd49;
  localparam logic [5:0] QUERY_GLYPH = 6'd50;

  localparam int CLEAR_TOTAL = 724;
  localparam int CLEAR_W = 10;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_FIRST_GLYPH = 8'h2A;
  localparam logic [7:0] CH_LAST_GLYPH  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  // 'a' maps onto the glyph of 'A'
  localparam logic [7:0] LOWER_FOLD    = 8'd74;

  // five columns per glyph, column 0 in the top byte
  localparam logic [39:0] FONT [GLYPH_COUNT] = '{
    40'h14083E0814, 40'h08083E0808, 40'h0000503000, 40'h1010101010,
    40'h0060600000, 40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10, 40'h2745454539,
    40'h3C4A494930, 40'h0171090503, 40'h3649494936, 40'h064949291E,
    40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7E1111117E,
    40'h7F49494936, 40'h3E41414122, 40'h7F4141221C, 40'h7F49494941,
    40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040, 40'h7F020C027F,
    40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463, 40'h0708700807,
    40'h6151494543, 40'h0000000000, 40'h0201510906
  };

  function automatic logic [5:0] glyph_index(input logic [7:0] c);
    logic [5:0] idx;
    if (c >= CH_FIRST_GLYPH && c <= CH_LAST_GLYPH) begin
      idx = 6'(c - CH_FIRST_GLYPH);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      idx = 6'(c - LOWER_FOLD);
    end else if (c == CH_SPACE || c == CH_NUL || c == CH_LF || c == CH_CR) begin
      idx = BLANK_GLYPH;
    end else begin
      idx = QUERY_GLYPH;
    end
    return idx;
  endfunction

  function automatic logic [7:0] font_column(input logic [5:0] g, input logic [2:0] col);
    logic [39:0] bits;
    logic [7:0]  b;
    bits = FONT[g];
    case (col)
      3'd0: b = bits[39:32];
      3'd1: b = bits[31:24];
      3'd2: b = bits[23:16];
      3'd3: b = bits[15:8];
      3'd4: b = bits[7:0];
      default: b = SPACER;
    endcase
    return b;
  endfunction

endpackage

FILE: design/stlr_if.sv
interface stlr_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] character;

  modport source(output valid, mode, character, input ready);
  modport sink(input valid, mode, character, output ready);
endinterface

interface stlr_result_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] out_byte;
  logic       is_data;
  logic       last_of_sequence;
  logic       busy_res;
  logic       changed;
  logic       rejected;

  modport source(output valid, byte_valid, out_byte, is_data, last_of_sequence, busy_res,
                 changed, rejected, input ready);
  modport sink(input valid, byte_valid, out_byte, is_data, last_of_sequence, busy_res,
               changed, rejected, output ready);
endinterface

FILE: design/stlr_ram.sv
module stlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 84
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/scrolling_text_lcd_renderer_core.sv
// the input word is registered at the edge that accepts it; the result word is loaded
//   into the output register when the execute state fires
// a new word is accepted only after the last one has been executed; the text store read
//   and the glyph lookup with state update run back to back for each word
// a full output register holds the update step until the result is taken
// reset: synchronous, active high; per-entry valid flags make the whole text
//   store read as blank at once, so no clearing pass is needed
module scrolling_text_lcd_renderer_core #(
  parameter int TEXT_COLUMNS = 14,
  parameter int TEXT_ROWS    = 6
) (
  input logic           clk,
  input logic           rst,
  stlr_item_if.sink     item,
  stlr_result_if.source result
);

  localparam int DEPTH  = TEXT_COLUMNS * TEXT_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CELL_W = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
  localparam int ROW_W  = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;
  typedef enum logic [1:0] {KIND_IDLE, KIND_REDRAW, KIND_CLEAR} kind_t;
  typedef enum logic [1:0] {PHASE_GOTO_X, PHASE_GOTO_Y, PHASE_CELLS} phase_t;

  function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : ADDR_W'(p + 1'b1);
  endfunction

  state_t                   state;
  stlr_pkg::mode_t          mode_q;
  logic [7:0]               char_q;

  logic [ADDR_W-1:0]        write_position, write_position_next;
  logic [ADDR_W-1:0]        redrawn_position, redrawn_position_next;
  kind_t                    kind, kind_next;
  phase_t                   phase, phase_next;
  logic [ROW_W-1:0]         row_count, row_count_next;
  logic [CELL_W-1:0]        cell_count, cell_count_next;
  logic [2:0]               column_count, column_count_next;
  logic [ADDR_W-1:0]        read_position, read_position_next;
  logic [stlr_pkg::CLEAR_W-1:0] clear_count, clear_count_next;
  logic [DEPTH-1:0]         written;

  logic       r_byte_valid, r_is_data, r_last, r_rejected;
  logic [7:0] r_byte;

  logic       out_full;
  logic       fire;
  logic       ram_we;
  logic [7:0] ram_rdata;
  logic [7:0] cell_char;

  stlr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_position_next),
    .wdata (char_q),
    .raddr (read_position),
    .rdata (ram_rdata)
  );

  assign item.ready = (state == ST_IDLE);
  assign fire       = (state == ST_EXEC) && (!out_full || result.ready);
  assign ram_we     = fire && (mode_q == stlr_pkg::MODE_APPEND) && (kind == KIND_IDLE);
  // entries never appended read as blank
  assign cell_char  = written[read_position] ? ram_rdata : stlr_pkg::CH_NUL;

  always_comb begin
    write_position_next   = write_position;
    redrawn_position_next = redrawn_position;
    kind_next             = kind;
    phase_next            = phase;
    row_count_next        = row_count;
    cell_count_next       = cell_count;
    column_count_next     = column_count;
    read_position_next    = read_position;
    clear_count_next      = clear_count;
    r_byte_valid          = 1'b0;
    r_byte                = stlr_pkg::SPACER;
    r_is_data             = 1'b0;
    r_last                = 1'b0;
    r_rejected            = 1'b0;

    if (mode_q != stlr_pkg::MODE_TICK && kind != KIND_IDLE) begin
      r_rejected = 1'b1;
    end else begin
      case (mode_q)
        stlr_pkg::MODE_APPEND: begin
          write_position_next = next_pos(write_position);
        end
        stlr_pkg::MODE_REDRAW: begin
          redrawn_position_next = write_position;
          read_position_next    = next_pos(write_position);
          kind_next             = KIND_REDRAW;
          phase_next            = PHASE_GOTO_X;
          row_count_next        = '0;
          cell_count_next       = '0;
          column_count_next     = '0;
        end
        stlr_pkg::MODE_CLEAR: begin
          kind_next        = KIND_CLEAR;
          clear_count_next = '0;
        end
        stlr_pkg::MODE_TICK: begin
          if (kind == KIND_CLEAR) begin
            r_byte_valid = 1'b1;
            if (clear_count == '0 ||
                clear_count == stlr_pkg::CLEAR_W'(stlr_pkg::CLEAR_TOTAL - 2)) begin
              r_byte = stlr_pkg::CMD_GOTO_X;
            end else if (clear_count == stlr_pkg::CLEAR_W'(1) ||
                         clear_count == stlr_pkg::CLEAR_W'(stlr_pkg::CLEAR_TOTAL - 1)) begin
              r_byte = stlr_pkg::CMD_GOTO_Y;
            end else begin
              r_is_data = 1'b1;
            end
            if (clear_count == stlr_pkg::CLEAR_W'(stlr_pkg::CLEAR_TOTAL - 1)) begin
              r_last           = 1'b1;
              clear_count_next = '0;
              kind_next        = KIND_IDLE;
            end else begin
              clear_count_next = clear_count + 1'b1;
            end
          end else if (kind == KIND_REDRAW) begin
            r_byte_valid = 1'b1;
            case (phase)
              PHASE_GOTO_X: begin
                r_byte     = stlr_pkg::CMD_GOTO_X;
                phase_next = PHASE_GOTO_Y;
              end
              PHASE_GOTO_Y: begin
                r_byte     = stlr_pkg::CMD_GOTO_Y | {5'b0, 3'(row_count)};
                phase_next = PHASE_CELLS;
              end
              PHASE_CELLS: begin
                r_is_data = 1'b1;
                if (column_count < 3'(stlr_pkg::GLYPH_COLS)) begin
                  r_byte = stlr_pkg::font_column(stlr_pkg::glyph_index(cell_char),
                                                 column_count);
                  column_count_next = column_count + 1'b1;
                end else begin
                  // spacer closes the cell
                  column_count_next  = '0;
                  read_position_next = next_pos(read_position);
                  if (cell_count == CELL_W'(TEXT_COLUMNS - 1)) begin
                    cell_count_next = '0;
                    phase_next      = PHASE_GOTO_X;
                    if (row_count == ROW_W'(TEXT_ROWS - 1)) begin
                      row_count_next = '0;
                      r_last         = 1'b1;
                      kind_next      = KIND_IDLE;
                    end else begin
                      row_count_next = row_count + 1'b1;
                    end
                  end else begin
                    cell_count_next = cell_count + 1'b1;
                  end
                end
              end
              default: begin
                phase_next = PHASE_GOTO_X;
              end
            endcase
          end
        end
        default: begin
          kind_next = kind;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_full         <= 1'b0;
      write_position   <= '0;
      redrawn_position <= '0;
      kind             <= KIND_IDLE;
      phase            <= PHASE_GOTO_X;
      row_count        <= '0;
      cell_count       <= '0;
      column_count     <= '0;
      read_position    <= '0;
      clear_count      <= '0;
      written          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            mode_q <= stlr_pkg::mode_t'(item.mode);
            char_q <= item.character;
            state  <= ST_EXEC;
          end
          if (result.ready) begin
            out_full <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state            <= ST_IDLE;
            out_full         <= 1'b1;
            write_position   <= write_position_next;
            redrawn_position <= redrawn_position_next;
            kind             <= kind_next;
            phase            <= phase_next;
            row_count        <= row_count_next;
            cell_count       <= cell_count_next;
            column_count     <= column_count_next;
            read_position    <= read_position_next;
            clear_count      <= clear_count_next;
            if (ram_we) begin
              written[write_position_next] <= 1'b1;
            end
            result.byte_valid       <= r_byte_valid;
            result.out_byte         <= r_byte;
            result.is_data          <= r_is_data;
            result.last_of_sequence <= r_last;
            result.busy_res         <= (kind_next != KIND_IDLE);
            result.changed          <= (write_position_next != redrawn_position_next);
            result.rejected         <= r_rejected;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign result.valid = out_full;

  a_store_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (kind == KIND_IDLE))
    else $error("text store written during a sequence");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    read_position < ADDR_W'(DEPTH))
    else $error("read position out of range");

  a_clear_in_range: assert property (@(posedge clk) disable iff (rst)
    clear_count < stlr_pkg::CLEAR_W'(stlr_pkg::CLEAR_TOTAL))
    else $error("clear count out of range");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state == ST_EXEC))
    else $error("accepted word not processed");

  a_last_ends_sequence: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_of_sequence) |-> (result.byte_valid && !result.busy_res))
    else $error("last byte leaves a sequence running");

endmodule
